>>> rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES = 16384;
  localparam int WORD_W    = 8;
  localparam int WORD_SH   = $clog2(WORD_W);
  localparam int WORDS     = NUM_PAGES / WORD_W;
  localparam int ADDR_W    = $clog2(WORDS);
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_FREE    = 2'd1;
  localparam op_t OP_RESERVE = 2'd2;
  localparam op_t OP_NONE    = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOMEM    = 2'd1;
  localparam status_t ST_FREE_OOB = 2'd2;
  localparam status_t ST_RES_IGN  = 2'd3;

endpackage

>>> rtl/bpa_ifs.sv
// ---------------------------------------------------------------------------
// bpa_ifs
// Request, response and configuration channels of the page allocator.
// ---------------------------------------------------------------------------
interface bpa_req_if;
  logic            valid;
  logic            ready;
  bpa_pkg::op_t    opcode;
  bpa_pkg::page_t  start_page;
  bpa_pkg::cnt_t   npages;
  modport source (output valid, output opcode, output start_page, output npages,
                  input ready);
  modport sink   (input valid, input opcode, input start_page, input npages,
                  output ready);
endinterface

interface bpa_rsp_if;
  logic              valid;
  logic              ready;
  bpa_pkg::page_t    result_page;
  bpa_pkg::status_t  status;
  modport source (output valid, output result_page, output status, input ready);
  modport sink   (input valid, input result_page, input status, output ready);
endinterface

interface bpa_cfg_if;
  logic           valid;
  logic           ready;
  bpa_pkg::cnt_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bitmap_page_allocator_top.sv
// ---------------------------------------------------------------------------
// bitmap_page_allocator_top
// Next-fit bitmap page frame allocator.
//
// Requests arrive on req (opcode, start_page, npages); one response per
// request leaves on rsp (result_page, status). cfg writes page_limit, which
// must be written only while the block is idle; the block does not enforce it.
// The used bitmap lives in a RAM of 8-bit words, one bit per page frame.
// Allocation scans word by word from the cursor (wrapping once to page 0),
// then marks the run with a read-modify-write per word. Free and reserve
// do a read-modify-write of each word touched. Out-of-bounds and zero-count
// requests go straight to the response without touching the RAM.
// One request is worked at a time; the next is taken once the current
// result sits in the output register, even if the receiver stalls it.
// After reset a clearing pass writes every word to all ones (every page
// used), during which req.ready stays low.
// A stalled response holds its payload until transferred.
// ---------------------------------------------------------------------------
module bitmap_page_allocator_top (
  input logic        clk,
  input logic        rst,
  bpa_req_if.sink    req,
  bpa_rsp_if.source  rsp,
  bpa_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_FILL_RD, S_FILL_WR, S_DONE
  } state_t;

  state_t                state;
  bpa_pkg::addr_t        clr_addr;
  bpa_pkg::addr_t        waddr;
  bpa_pkg::cnt_t         page_limit;
  bpa_pkg::cnt_t         cursor;
  bpa_pkg::cnt_t         cnt;
  bpa_pkg::cnt_t         scan_from;
  bpa_pkg::cnt_t         scan_end;
  bpa_pkg::cnt_t         run;
  bpa_pkg::cnt_t         fill_s;
  bpa_pkg::cnt_t         fill_e;
  logic                  fill_val;
  logic                  pass2;
  bpa_pkg::page_t        res_page;
  bpa_pkg::status_t      res_status;

  logic                  ram_we;
  bpa_pkg::addr_t        ram_addr;
  bpa_pkg::word_t        ram_wdata;
  bpa_pkg::word_t        ram_rdata;

  bpa_pkg::cnt_t         lim;
  bpa_pkg::cnt_t         next_word_page;
  logic [bpa_pkg::CNT_W:0] range_end;
  bpa_pkg::cnt_t         end2;

  logic                  hit;
  bpa_pkg::cnt_t         hit_page;
  bpa_pkg::cnt_t         run_next;
  bpa_pkg::word_t        fill_mask;

  bpa_ram #(.WIDTH(bpa_pkg::WORD_W), .DEPTH(bpa_pkg::WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign lim = (page_limit > bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES)) ?
               bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES) : page_limit;
  assign next_word_page = bpa_pkg::CNT_W'({1'b0, waddr} + 1'b1) << bpa_pkg::WORD_SH;
  assign range_end = {1'b0, bpa_pkg::CNT_W'(req.start_page)} + {1'b0, req.npages};
  assign end2 = (cursor < lim) ? cursor : lim;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign ram_addr  = (state == S_CLR) ? clr_addr : waddr;
  assign ram_we    = (state == S_CLR) || (state == S_FILL_WR);
  assign ram_wdata = (state == S_CLR) ? '1 :
                     (fill_val ? (ram_rdata | fill_mask) : (ram_rdata & ~fill_mask));

  // Run search over the word just read, first hit wins
  always_comb begin
    bpa_pkg::cnt_t p;
    run_next = run;
    hit      = 1'b0;
    hit_page = '0;
    for (int i = 0; i < bpa_pkg::WORD_W; i++) begin
      p = bpa_pkg::CNT_W'({waddr, bpa_pkg::WORD_SH'(i)});
      if (!hit && p >= scan_from && p < scan_end) begin
        run_next = ram_rdata[i] ? '0 : run_next + 1'b1;
        if (run_next == cnt) begin
          hit      = 1'b1;
          hit_page = p + 1'b1 - cnt;
        end
      end
    end
  end

  always_comb begin
    bpa_pkg::cnt_t p;
    fill_mask = '0;
    for (int i = 0; i < bpa_pkg::WORD_W; i++) begin
      p = bpa_pkg::CNT_W'({waddr, bpa_pkg::WORD_SH'(i)});
      fill_mask[i] = (p >= fill_s) && (p < fill_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      page_limit <= bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES);
      cursor     <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        page_limit <= cfg.data;
      end
      // a new result loads in S_DONE, otherwise drop valid after the transfer
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == bpa_pkg::addr_t'(bpa_pkg::WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cnt      <= req.npages;
            res_page <= '0;
            run      <= '0;
            unique case (req.opcode)
              bpa_pkg::OP_ALLOC: begin
                if (req.npages == '0) begin
                  res_status <= bpa_pkg::ST_NOMEM;
                  state      <= S_DONE;
                end else if (cursor < lim) begin
                  res_status <= bpa_pkg::ST_OK;
                  scan_from  <= cursor;
                  scan_end   <= lim;
                  pass2      <= 1'b0;
                  waddr      <= cursor[bpa_pkg::PAGE_W-1:bpa_pkg::WORD_SH];
                  state      <= S_SCAN_RD;
                end else begin
                  // stale cursor: go straight to the wrapped pass
                  cursor <= '0;
                  if (end2 == '0) begin
                    res_status <= bpa_pkg::ST_NOMEM;
                    state      <= S_DONE;
                  end else begin
                    res_status <= bpa_pkg::ST_OK;
                    scan_from  <= '0;
                    scan_end   <= end2;
                    pass2      <= 1'b1;
                    waddr      <= '0;
                    state      <= S_SCAN_RD;
                  end
                end
              end
              bpa_pkg::OP_FREE, bpa_pkg::OP_RESERVE: begin
                if (range_end > {1'b0, lim}) begin
                  res_status <= (req.opcode == bpa_pkg::OP_FREE) ?
                                bpa_pkg::ST_FREE_OOB : bpa_pkg::ST_RES_IGN;
                  state      <= S_DONE;
                end else if (req.npages != '0) begin
                  res_status <= bpa_pkg::ST_OK;
                  fill_s     <= bpa_pkg::CNT_W'(req.start_page);
                  fill_e     <= range_end[bpa_pkg::CNT_W-1:0];
                  fill_val   <= (req.opcode == bpa_pkg::OP_RESERVE);
                  waddr      <= req.start_page[bpa_pkg::PAGE_W-1:bpa_pkg::WORD_SH];
                  state      <= S_FILL_RD;
                end else begin
                  res_status <= bpa_pkg::ST_OK;
                  state      <= S_DONE;
                end
              end
              default: begin
                res_status <= bpa_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (hit) begin
            fill_s   <= hit_page;
            fill_e   <= hit_page + cnt;
            fill_val <= 1'b1;
            res_page <= hit_page[bpa_pkg::PAGE_W-1:0];
            cursor   <= hit_page + cnt;
            waddr    <= hit_page[bpa_pkg::PAGE_W-1:bpa_pkg::WORD_SH];
            state    <= S_FILL_RD;
          end else if (next_word_page >= scan_end) begin
            if (!pass2) begin
              cursor <= '0;
              if (end2 == '0) begin
                res_status <= bpa_pkg::ST_NOMEM;
                state      <= S_DONE;
              end else begin
                scan_from <= '0;
                scan_end  <= end2;
                pass2     <= 1'b1;
                waddr     <= '0;
                run       <= '0;
                state     <= S_SCAN_RD;
              end
            end else begin
              res_status <= bpa_pkg::ST_NOMEM;
              state      <= S_DONE;
            end
          end else begin
            waddr <= waddr + 1'b1;
            run   <= run_next;
            state <= S_SCAN_RD;
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          if (next_word_page >= fill_e) begin
            state <= S_DONE;
          end else begin
            waddr <= waddr + 1'b1;
            state <= S_FILL_RD;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.result_page <= res_page;
            rsp.status      <= res_status;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bpa_ram.sv
// ---------------------------------------------------------------------------
// bpa_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/bpa_checker.sv
// ---------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ---------------------------------------------------------------------------
module bpa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bpa_pkg::page_t    rsp_result_page,
  input bpa_pkg::status_t  rsp_status
);

  // a stalled response stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_fail_page_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != bpa_pkg::ST_OK |-> rsp_result_page == '0)
    else $error("failed request carries a page");

  // one request at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && !req_ready)
    else $error("activity right after reset");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_result_page (rsp.result_page),
  .rsp_status      (rsp.status)
);
